// File: rtl/core/rbsw_pkg.sv
// shared types, constants and byte helpers for the rgb565 to bmp stream writer
// no dependencies
package rbsw_pkg;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;

	localparam logic [5:0] HDR_BYTES = 6'd54;
	localparam logic [5:0] POS_BLUE  = 6'd54;
	localparam logic [5:0] POS_GREEN = 6'd55;
	localparam logic [5:0] POS_RED   = 6'd56;

	localparam logic [15:0] RESET_WIDTH  = 16'd320;
	localparam logic [15:0] RESET_HEIGHT = 16'd240;
	localparam logic [15:0] PELS_PER_M   = 16'd2835;
	localparam logic [7:0]  INFO_SIZE    = 8'd40;
	localparam logic [7:0]  BITS_PER_PEL = 8'd24;
	localparam logic [7:0]  CHAR_B       = 8'h42;
	localparam logic [7:0]  CHAR_M       = 8'h4D;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_BIG  = 2'd2
	} status_t;

	// frame geometry that the byte sequencer needs for the header
	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] file_bytes;
		logic [31:0] image_bytes;
	} frame_geom_t;

	// one classified pixel request
	typedef struct packed {
		logic [15:0] pixel;
		logic        hdr;
		logic [1:0]  pad;
		logic        eof;
		status_t     status;
	} entry_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		widen5 = {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		widen6 = {v, v[5:4]};
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input frame_geom_t g);
		logic [7:0] b;
		b = 8'd0;
		case (idx)
			6'd0:  b = CHAR_B;
			6'd1:  b = CHAR_M;
			6'd2:  b = g.file_bytes[7:0];
			6'd3:  b = g.file_bytes[15:8];
			6'd4:  b = g.file_bytes[23:16];
			6'd5:  b = g.file_bytes[31:24];
			6'd10: b = {2'b00, HDR_BYTES};
			6'd14: b = INFO_SIZE;
			6'd18: b = g.width[7:0];
			6'd19: b = g.width[15:8];
			6'd22: b = g.height[7:0];
			6'd23: b = g.height[15:8];
			6'd26: b = 8'd1;
			6'd28: b = BITS_PER_PEL;
			6'd34: b = g.image_bytes[7:0];
			6'd35: b = g.image_bytes[15:8];
			6'd36: b = g.image_bytes[23:16];
			6'd37: b = g.image_bytes[31:24];
			6'd38: b = PELS_PER_M[7:0];
			6'd39: b = PELS_PER_M[15:8];
			6'd42: b = PELS_PER_M[7:0];
			6'd43: b = PELS_PER_M[15:8];
			default: b = 8'd0;
		endcase
		hdr_byte = b;
	endfunction

endpackage

// File: rtl/core/rgb565_bmp_stream_writer_unit.sv
// top level of the rgb565 to 24-bit bmp byte stream writer
// instantiates rbsw_front, rbsw_queue and rbsw_back; uses rbsw_pkg
//
// usage: pixels enter on in_valid/in_stall in file order (bottom row first,
// left to right); bytes leave on out_valid/out_stall, one per cycle while
// out_stall is low. the first pixel of a frame produces the 54-byte header,
// then three bytes (blue, green, red); the last pixel of a row adds zero
// pad bytes up to a four-byte boundary. last_of_run marks the final byte of
// each pixel, end_of_frame the final byte of the file. zero size or a file
// beyond 32 bits gives a single zero byte with status 1 or 2 and drops the
// pixel. frame_width (index 0) and frame_height (index 1) are written on
// cfg_*; a write restarts the frame. after reset or a write, in_stall is
// held while the size pipeline (shift-add, multiplier, adder) runs. a pixel
// accepted is written into the request queue, and from there its first byte
// into the output register. the byte sequencer sends one byte per cycle
// while out_stall is low, three bytes per pixel, 57 for a header pixel,
// plus pad at row ends. a stalled receiver holds the output register; the
// request queue keeps taking pixels until it is full, then in_stall rises.
module rgb565_bmp_stream_writer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbsw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    pixel_rgb565,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last_of_run,
	output logic                           end_of_frame,
	output logic [1:0]                     status
);

	rbsw_pkg::entry_t      push_entry, head;
	rbsw_pkg::frame_geom_t geom;
	logic                  q_push, q_pop, q_empty, q_full;

	rbsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_rgb565 (pixel_rgb565),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (push_entry),
		.geom         (geom)
	);

	rbsw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	rbsw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (q_pop),
		.geom         (geom),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.status       (status)
	);

endmodule

// File: rtl/core/rbsw_front.sv
// front end: size registers, derived file sizes, row and column counters,
// classifies each pixel into a queue entry; uses rbsw_pkg
module rbsw_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rbsw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [15:0]                  pixel_rgb565,
	input  logic                         q_full,
	output logic                         q_push,
	output rbsw_pkg::entry_t             q_entry,
	output rbsw_pkg::frame_geom_t        geom
);

	logic [15:0] width_q, height_q;
	logic [15:0] col_q, row_q;
	logic [1:0]  settle_q;

	logic [17:0] row_bytes_s1;
	logic [1:0]  pad_s1;
	logic        zero_s1;
	logic [33:0] image_bytes_s2;
	logic [31:0] file_bytes_s3;
	logic [31:0] image_bytes_s3;
	logic        oversize_s3;

	logic [17:0] raw_row;
	logic        cfg_we, cfg_hit, accept, size_ok, end_row, end_frame, first_pel;
	logic [16:0] col_next, row_next;
	logic [34:0] file_sum;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign cfg_hit   = cfg_we & ((cfg_index == rbsw_pkg::REG_WIDTH) ||
		(cfg_index == rbsw_pkg::REG_HEIGHT));

	assign raw_row  = {1'b0, width_q, 1'b0} + {2'b00, width_q};
	assign file_sum = {1'b0, image_bytes_s2} + {29'd0, rbsw_pkg::HDR_BYTES};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbsw_pkg::RESET_WIDTH;
			height_q <= rbsw_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			if (cfg_index == rbsw_pkg::REG_WIDTH)
				width_q <= cfg_data;
			else if (cfg_index == rbsw_pkg::REG_HEIGHT)
				height_q <= cfg_data;
		end
	end

	// size derivation runs freely; settle_q holds off pixels until it is through
	always_ff @(posedge clk) begin
		row_bytes_s1   <= (raw_row + 18'd3) & ~18'd3;
		pad_s1         <= 2'd0 - raw_row[1:0];
		zero_s1        <= (width_q == 16'd0) || (height_q == 16'd0);
		image_bytes_s2 <= row_bytes_s1 * height_q;
		file_bytes_s3  <= file_sum[31:0];
		image_bytes_s3 <= image_bytes_s2[31:0];
		oversize_s3    <= (file_sum[34:32] != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			settle_q <= 2'd3;
		else if (cfg_we)
			settle_q <= 2'd3;
		else if (settle_q != 2'd0)
			settle_q <= settle_q - 2'd1;
	end

	assign in_stall = (settle_q != 2'd0) || q_full;
	assign accept   = in_valid & ~in_stall;
	assign size_ok  = ~zero_s1 & ~oversize_s3;

	assign col_next  = {1'b0, col_q} + 17'd1;
	assign row_next  = {1'b0, row_q} + 17'd1;
	assign end_row   = col_next >= {1'b0, width_q};
	assign end_frame = end_row && (row_next >= {1'b0, height_q});
	assign first_pel = (col_q == 16'd0) && (row_q == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 16'd0;
			row_q <= 16'd0;
		end else if (cfg_hit) begin
			col_q <= 16'd0;
			row_q <= 16'd0;
		end else if (accept && size_ok) begin
			if (end_row) begin
				col_q <= 16'd0;
				row_q <= end_frame ? 16'd0 : row_next[15:0];
			end else begin
				col_q <= col_next[15:0];
			end
		end
	end

	always_comb begin
		q_push          = accept;
		q_entry.pixel   = pixel_rgb565;
		q_entry.hdr     = first_pel & size_ok;
		q_entry.pad     = (end_row & size_ok) ? pad_s1 : 2'd0;
		q_entry.eof     = end_frame & size_ok;
		if (zero_s1)
			q_entry.status = rbsw_pkg::ST_ZERO;
		else if (oversize_s3)
			q_entry.status = rbsw_pkg::ST_BIG;
		else
			q_entry.status = rbsw_pkg::ST_OK;
	end

	assign geom.width       = width_q;
	assign geom.height      = height_q;
	assign geom.file_bytes  = file_bytes_s3;
	assign geom.image_bytes = image_bytes_s3;

endmodule

// File: rtl/core/rbsw_queue.sv
// short request queue between the front end and the byte sequencer
// uses rbsw_pkg for the entry type
module rbsw_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rbsw_pkg::entry_t push_entry,
	input  logic             pop,
	output rbsw_pkg::entry_t head,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	rbsw_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == CNT_W'(0));
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: rtl/core/rbsw_back.sv
// byte sequencer: walks header, pixel and pad bytes of the head request
// into the output register; uses rbsw_pkg
module rbsw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rbsw_pkg::entry_t      head,
	input  logic                  empty,
	output logic                  pop,
	input  rbsw_pkg::frame_geom_t geom,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  last_of_run,
	output logic                  end_of_frame,
	output logic [1:0]            status
);

	logic       first_q;
	logic [5:0] pos_q;
	logic       out_valid_q, last_q, eof_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;

	logic       load, emit, is_last, bad;
	logic [5:0] idx, last_idx;
	logic [7:0] byte_d;

	assign bad      = (head.status != rbsw_pkg::ST_OK);
	assign idx      = first_q ? (head.hdr ? 6'd0 : rbsw_pkg::POS_BLUE) : pos_q;
	assign last_idx = rbsw_pkg::POS_RED + {4'd0, head.pad};
	assign is_last  = bad || (idx == last_idx);
	assign load     = ~out_valid_q | ~out_stall;
	assign emit     = load & ~empty;
	assign pop      = emit & is_last;

	always_comb begin
		byte_d = 8'd0;
		if (!bad) begin
			if (idx < rbsw_pkg::HDR_BYTES)
				byte_d = rbsw_pkg::hdr_byte(idx, geom);
			else if (idx == rbsw_pkg::POS_BLUE)
				byte_d = rbsw_pkg::widen5(head.pixel[4:0]);
			else if (idx == rbsw_pkg::POS_GREEN)
				byte_d = rbsw_pkg::widen6(head.pixel[10:5]);
			else if (idx == rbsw_pkg::POS_RED)
				byte_d = rbsw_pkg::widen5(head.pixel[15:11]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			pos_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= ~empty;
			if (emit) begin
				first_q <= is_last;
				pos_q   <= idx + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q   <= byte_d;
			last_q   <= is_last;
			eof_q    <= is_last & head.eof & ~bad;
			status_q <= head.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;
	assign status       = status_q;

endmodule
